### hw/rtl/sdta_pkg.sv
`default_nettype none

package sdta_pkg;

  // character code width on the result port
  localparam int CHAR_BITS = 6;

  // one BCD digit
  localparam int DIGIT_BITS = 4;

  // ASCII codes, sized to the port width
  localparam logic [CHAR_BITS-1:0] CODE_MINUS = 6'd45;
  localparam logic [CHAR_BITS-1:0] CODE_ZERO  = 6'd48;

  // shift-add-3 correction threshold for one BCD digit
  localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_BITS-1:0] DABBLE_ADD   = 4'd3;

endpackage

`default_nettype wire

### hw/rtl/sdta_front.sv
`default_nettype none

// Front end: takes the signed value, splits it into sign and magnitude
// and writes the pair into the work queue.
module sdta_front #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                         push,
  input  wire logic signed [VALUE_BITS-1:0] value,
  input  wire logic                         q_full,
  output logic                              q_push,
  output logic             [VALUE_BITS:0]   q_data
);

  logic                  negative;
  logic [VALUE_BITS-1:0] magnitude;

  // two's complement magnitude; the most negative value maps to 2^(n-1)
  always_comb begin
    negative  = value[VALUE_BITS-1];
    magnitude = negative ? (~value + 1'b1) : value;
  end

  assign q_push = push && !q_full;
  assign q_data = {negative, magnitude};

endmodule

`default_nettype wire

### hw/rtl/sdta_fifo.sv
`default_nettype none

// Two-entry queue between the front end and the converter.
module sdta_fifo #(
  parameter int WIDTH = 33
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr_en && !rd_en) begin
        count <= count + 2'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sdta_back.sv
`default_nettype none

// Back end: binary to BCD by shift-add-3, one magnitude bit per cycle,
// then one character per cycle into the output register while it is free.
module sdta_back #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_empty,
  input  wire logic [VALUE_BITS:0]               q_data,
  output logic                                   q_pop,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic      [sdta_pkg::CHAR_BITS-1:0]    char_code,
  output logic                                   last
);

  // decimal digits of 2^(VALUE_BITS-1); log10(2) ~ 0.30103
  localparam int NDIG   = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int IDX_W  = $clog2(NDIG);
  localparam int CNT_W  = $clog2(VALUE_BITS);
  localparam int BCD_W  = NDIG * sdta_pkg::DIGIT_BITS;
  localparam int DW     = sdta_pkg::DIGIT_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [VALUE_BITS-1:0] mag;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic [CNT_W-1:0]      cnt;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      lead;
  logic                  sign_pend;
  logic                  out_valid;
  logic                  load;
  logic [DW-1:0]         digit;

  assign empty = !out_valid;
  assign load  = !out_valid || pop;
  assign q_pop = (state == ST_IDLE) && !q_empty;
  assign digit = bcd[idx*DW +: DW];

  // add-3 correction on every BCD digit
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*DW +: DW] >= sdta_pkg::DABBLE_LIMIT) begin
        bcd_adj[i*DW +: DW] = bcd[i*DW +: DW] + sdta_pkg::DABBLE_ADD;
      end else begin
        bcd_adj[i*DW +: DW] = bcd[i*DW +: DW];
      end
    end
  end

  // most significant nonzero digit, zero when all digits are zero
  always_comb begin
    lead = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*DW +: DW] != '0) begin
        lead = IDX_W'(i);
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (cnt == CNT_W'(VALUE_BITS - 1)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (load && !sign_pend && idx == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= (state == ST_EMIT);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        sign_pend <= q_data[VALUE_BITS];
        mag       <= q_data[VALUE_BITS-1:0];
        bcd       <= '0;
        cnt       <= '0;
      end
      ST_CONV: begin
        bcd <= {bcd_adj[BCD_W-2:0], mag[VALUE_BITS-1]};
        mag <= {mag[VALUE_BITS-2:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      ST_SCAN: begin
        idx <= lead;
      end
      ST_EMIT: begin
        if (load) begin
          if (sign_pend) begin
            char_code <= sdta_pkg::CODE_MINUS;
            last      <= 1'b0;
            sign_pend <= 1'b0;
          end else begin
            char_code <= sdta_pkg::CODE_ZERO + sdta_pkg::CHAR_BITS'(digit);
            last      <= (idx == '0);
            if (idx != '0) begin
              idx <= idx - 1'b1;
            end
          end
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/signed_int_to_decimal_ascii_unit.sv
`default_nettype none

// Channel  | Ports                 | Direction | Handshake
// ---------+-----------------------+-----------+---------------------------
// input    | value                 | in        | push / full
// result   | char_code, last       | out       | pop / empty
//
// Per number: the value leaves the queue, shift-add-3 takes in one magnitude
// bit per cycle, the leading digit is found, then one character goes out per
// cycle while the output register is free. The back end converts one number
// at a time; the two-entry queue lets the input side take values while
// characters drain. Reset (rst, synchronous) empties the queue and the output
// register; pop low holds the current character, and the back end waits in
// its emit step until the output register frees up.
module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic signed [VALUE_BITS-1:0]    value,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic             [sdta_pkg::CHAR_BITS-1:0] char_code,
  output logic                                 last
);

  logic                q_push;
  logic [VALUE_BITS:0] q_wr_data;
  logic                q_full;
  logic                q_pop;
  logic [VALUE_BITS:0] q_rd_data;
  logic                q_empty;

  assign full = q_full;

  sdta_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .push   (push),
    .value  (value),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  sdta_fifo #(
    .WIDTH (VALUE_BITS + 1)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  sdta_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .char_code (char_code),
    .last      (last)
  );

endmodule

`default_nettype wire
